/* rtl/tsu_pkg.sv */
`timescale 1ns / 1ps
package tsu_pkg;

  localparam int THREAD_SLOTS  = 16;
  localparam int LOCK_COUNT    = 8;
  localparam int CONDVAR_COUNT = 8;

  localparam int NUM_QUEUES = THREAD_SLOTS + LOCK_COUNT + CONDVAR_COUNT;
  localparam int SLOT_W     = $clog2(THREAD_SLOTS);
  localparam int QUEUE_W    = $clog2(NUM_QUEUES);
  localparam int CNT_W      = $clog2(THREAD_SLOTS + 1);
  localparam int LOCK_W     = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
  localparam int CV_W       = (CONDVAR_COUNT > 1) ? $clog2(CONDVAR_COUNT) : 1;
  localparam int RAM_DEPTH  = NUM_QUEUES * (2 ** SLOT_W);

  // fixed field widths of the request and response
  localparam int ACTION_W  = 3;
  localparam int TARGET_W  = 4;
  localparam int LOCKIDX_W = 3;
  localparam int CVIDX_W   = 3;
  localparam int SLOTOUT_W = 4;
  localparam int OUTCOME_W = 3;
  localparam int ST_W      = 3;

  typedef logic [SLOT_W-1:0]    slot_t;
  typedef logic [ST_W-1:0]      status_t;
  typedef logic [CNT_W-1:0]     count_t;
  typedef logic [QUEUE_W-1:0]   qid_t;
  typedef logic [ACTION_W-1:0]  action_t;
  typedef logic [OUTCOME_W-1:0] outcome_t;

  localparam action_t ACT_CREATE = 3'd0;
  localparam action_t ACT_YIELD  = 3'd1;
  localparam action_t ACT_JOIN   = 3'd2;
  localparam action_t ACT_EXIT   = 3'd3;
  localparam action_t ACT_LOCK   = 3'd4;
  localparam action_t ACT_UNLOCK = 3'd5;
  localparam action_t ACT_WAIT   = 3'd6;
  localparam action_t ACT_SIGNAL = 3'd7;

  localparam status_t ST_ABSENT  = 3'd0;
  localparam status_t ST_RUNNING = 3'd1;
  localparam status_t ST_WAITING = 3'd2;
  localparam status_t ST_READY   = 3'd3;
  localparam status_t ST_EXITED  = 3'd4;

  localparam outcome_t OC_OK       = 3'd0;
  localparam outcome_t OC_NO_SLOT  = 3'd1;
  localparam outcome_t OC_NO_READY = 3'd2;
  localparam outcome_t OC_ABSENT   = 3'd3;
  localparam outcome_t OC_EXITED   = 3'd4;

  // slot arithmetic modulo THREAD_SLOTS, both operands below THREAD_SLOTS
  function automatic slot_t slot_add(slot_t a, slot_t b);
    logic [SLOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (SLOT_W+1)'(THREAD_SLOTS)) begin
      s = s - (SLOT_W+1)'(THREAD_SLOTS);
    end
    return s[SLOT_W-1:0];
  endfunction

endpackage

/* rtl/tsu_in_if.sv */
`timescale 1ns / 1ps
interface tsu_in_if;
  import tsu_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ACTION_W-1:0]  action;
  logic [TARGET_W-1:0]  target_thread;
  logic [LOCKIDX_W-1:0] lock_index;
  logic [CVIDX_W-1:0]   condvar_index;

  modport source (output valid, action, target_thread, lock_index, condvar_index,
                  input ready);
  modport sink (input valid, action, target_thread, lock_index, condvar_index,
                output ready);
endinterface

/* rtl/tsu_out_if.sv */
`timescale 1ns / 1ps
interface tsu_out_if;
  import tsu_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [SLOTOUT_W-1:0] running_thread;
  logic [SLOTOUT_W-1:0] created_thread;
  logic                 switched;
  logic [OUTCOME_W-1:0] outcome;

  modport source (output valid, running_thread, created_thread, switched, outcome,
                  input ready);
  modport sink (input valid, running_thread, created_thread, switched, outcome,
                output ready);
endinterface

/* rtl/tsu_ram.sv */
`timescale 1ns / 1ps
module tsu_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wr_data,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wr_data;
    end
    rd_data_r <= mem_r[addr];
  end

  assign rd_data = rd_data_r;
endmodule

/* rtl/thread_scheduler_sync_unit.sv */
`timescale 1ns / 1ps
// each request runs a round-robin scan over all THREAD_SLOTS slots, then queue walks
//   (duplicate check on push, joiner walk on exit), plus a second scan on exit and wait
// one request at a time, served by the scan loop and the single queue ram port
// reset: slot 0 running, all others absent, all queues empty, all locks free
module thread_scheduler_sync_unit (
  input  logic      clk,
  input  logic      rst_n,
  tsu_in_if.sink    in_req,
  tsu_out_if.source out_rsp
);
  import tsu_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DISP   = 3'd2;
  localparam logic [2:0] S_QRD    = 3'd3;
  localparam logic [2:0] S_QDAT   = 3'd4;
  localparam logic [2:0] S_SWITCH = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  // queue operations of the shared queue walker
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_POP   = 2'd1;
  localparam logic [1:0] OP_PEEK  = 2'd2;
  localparam logic [1:0] OP_SCANQ = 2'd3;

  logic [2:0] state_r, state_nxt;
  logic [1:0] step_r, step_nxt;

  // latched request
  action_t              act_r, act_nxt;
  logic [TARGET_W-1:0]  tgt_r, tgt_nxt;
  logic [LOCKIDX_W-1:0] li_r, li_nxt;
  logic [CVIDX_W-1:0]   ci_r, ci_nxt;

  // scheduler state
  status_t                 status_r [THREAD_SLOTS];
  status_t                 status_nxt [THREAD_SLOTS];
  slot_t                   cur_r, cur_nxt;
  slot_t                   head_r [NUM_QUEUES];
  slot_t                   head_nxt [NUM_QUEUES];
  count_t                  count_r [NUM_QUEUES];
  count_t                  count_nxt [NUM_QUEUES];
  logic [LOCK_COUNT-1:0]   held_r, held_nxt;
  slot_t                   owner_r [LOCK_COUNT];
  slot_t                   owner_nxt [LOCK_COUNT];

  // scan and work registers
  slot_t                   k_r, k_nxt;
  logic                    abs_found_r, abs_found_nxt;
  slot_t                   abs_idx_r, abs_idx_nxt;
  logic                    nr_found_r, nr_found_nxt;
  slot_t                   nr_idx_r, nr_idx_nxt;
  logic                    rescan_r, rescan_nxt;
  status_t                 mark_r, mark_nxt;
  logic [1:0]              op_r, op_nxt;
  qid_t                    q_r, q_nxt;
  slot_t                   val_r, val_nxt;
  count_t                  i_r, i_nxt;
  slot_t                   w_r, w_nxt;
  logic                    peek_ok_r, peek_ok_nxt;
  logic [THREAD_SLOTS-1:0] mask_r, mask_nxt;
  slot_t                   created_r, created_nxt;
  outcome_t                outcome_r, outcome_nxt;
  slot_t                   before_r, before_nxt;

  // response register
  logic                 out_valid_r, out_valid_nxt;
  logic [SLOTOUT_W-1:0] out_run_r, out_run_nxt;
  logic [SLOTOUT_W-1:0] out_created_r, out_created_nxt;
  logic                 out_sw_r, out_sw_nxt;
  outcome_t             out_oc_r, out_oc_nxt;

  // queue ram
  logic                      ram_we;
  logic [QUEUE_W+SLOT_W-1:0] ram_addr;
  slot_t                     ram_wdata;
  slot_t                     ram_rdata;

  tsu_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (RAM_DEPTH)
  ) u_queue_ram (
    .clk     (clk),
    .we      (ram_we),
    .addr    (ram_addr),
    .wr_data (ram_wdata),
    .rd_data (ram_rdata)
  );

  // decoded request fields
  logic          tgt_ok, li_ok, ci_ok, held_li;
  slot_t         tgt_idx;
  logic [LOCK_W-1:0] li_idx;
  logic [CV_W-1:0]   ci_idx;
  qid_t          lock_q, cv_q, cur_q;
  slot_t         ridx;
  count_t        qcnt;
  slot_t         qhd;

  assign tgt_ok  = 32'(tgt_r) < THREAD_SLOTS;
  assign li_ok   = 32'(li_r) < LOCK_COUNT;
  assign ci_ok   = 32'(ci_r) < CONDVAR_COUNT;
  assign tgt_idx = SLOT_W'(tgt_r);
  assign li_idx  = LOCK_W'(li_r);
  assign ci_idx  = CV_W'(ci_r);
  assign lock_q  = QUEUE_W'(THREAD_SLOTS) + QUEUE_W'(li_idx);
  assign cv_q    = QUEUE_W'(THREAD_SLOTS + LOCK_COUNT) + QUEUE_W'(ci_idx);
  assign cur_q   = QUEUE_W'(cur_r);
  assign held_li = held_r[li_idx];
  assign ridx    = slot_add(cur_r, k_r);
  assign qcnt    = count_r[q_r];
  assign qhd     = head_r[q_r];

  assign in_req.ready           = (state_r == S_IDLE);
  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.running_thread = out_run_r;
  assign out_rsp.created_thread = out_created_r;
  assign out_rsp.switched       = out_sw_r;
  assign out_rsp.outcome        = out_oc_r;

  always_comb begin
    state_nxt       = state_r;
    step_nxt        = step_r;
    act_nxt         = act_r;
    tgt_nxt         = tgt_r;
    li_nxt          = li_r;
    ci_nxt          = ci_r;
    status_nxt      = status_r;
    cur_nxt         = cur_r;
    head_nxt        = head_r;
    count_nxt       = count_r;
    held_nxt        = held_r;
    owner_nxt       = owner_r;
    k_nxt           = k_r;
    abs_found_nxt   = abs_found_r;
    abs_idx_nxt     = abs_idx_r;
    nr_found_nxt    = nr_found_r;
    nr_idx_nxt      = nr_idx_r;
    rescan_nxt      = rescan_r;
    mark_nxt        = mark_r;
    op_nxt          = op_r;
    q_nxt           = q_r;
    val_nxt         = val_r;
    i_nxt           = i_r;
    w_nxt           = w_r;
    peek_ok_nxt     = peek_ok_r;
    mask_nxt        = mask_r;
    created_nxt     = created_r;
    outcome_nxt     = outcome_r;
    before_nxt      = before_r;
    out_valid_nxt   = out_valid_r;
    out_run_nxt     = out_run_r;
    out_created_nxt = out_created_r;
    out_sw_nxt      = out_sw_r;
    out_oc_nxt      = out_oc_r;
    ram_we          = 1'b0;
    ram_addr        = {q_r, slot_add(qhd, SLOT_W'(i_r))};
    ram_wdata       = val_r;

    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          act_nxt       = in_req.action;
          tgt_nxt       = in_req.target_thread;
          li_nxt        = in_req.lock_index;
          ci_nxt        = in_req.condvar_index;
          k_nxt         = '0;
          abs_found_nxt = 1'b0;
          nr_found_nxt  = 1'b0;
          rescan_nxt    = 1'b0;
          step_nxt      = '0;
          peek_ok_nxt   = 1'b0;
          mask_nxt      = '0;
          created_nxt   = '0;
          outcome_nxt   = OC_OK;
          before_nxt    = cur_r;
          state_nxt     = S_SCAN;
        end
      end

      // one slot a cycle: lowest absent slot and first ready slot after current
      S_SCAN: begin
        if (!abs_found_r && status_r[k_r] == ST_ABSENT) begin
          abs_found_nxt = 1'b1;
          abs_idx_nxt   = k_r;
        end
        if (k_r != '0 && !nr_found_r && status_r[ridx] == ST_READY) begin
          nr_found_nxt = 1'b1;
          nr_idx_nxt   = ridx;
        end
        if (k_r == SLOT_W'(THREAD_SLOTS - 1)) begin
          state_nxt = rescan_r ? S_SWITCH : S_DISP;
        end else begin
          k_nxt = k_r + SLOT_W'(1);
        end
      end

      // per-action sequencing; queue operations return here with step advanced
      S_DISP: begin
        state_nxt = S_OUT;
        case (act_r)
          ACT_CREATE: begin
            if (!abs_found_r) begin
              outcome_nxt = OC_NO_SLOT;
            end else begin
              head_nxt[QUEUE_W'(abs_idx_r)]  = '0;
              count_nxt[QUEUE_W'(abs_idx_r)] = '0;
              status_nxt[cur_r]     = ST_READY;
              status_nxt[abs_idx_r] = ST_RUNNING;
              cur_nxt     = abs_idx_r;
              created_nxt = abs_idx_r;
            end
          end
          ACT_YIELD: begin
            if (!nr_found_r) begin
              outcome_nxt = OC_NO_READY;
            end else begin
              mark_nxt  = ST_READY;
              state_nxt = S_SWITCH;
            end
          end
          ACT_JOIN: begin
            if (step_r == 2'd0) begin
              if (!tgt_ok || tgt_idx == cur_r || status_r[tgt_idx] == ST_ABSENT) begin
                outcome_nxt = OC_ABSENT;
              end else if (status_r[tgt_idx] == ST_EXITED) begin
                status_nxt[tgt_idx]          = ST_ABSENT;
                head_nxt[QUEUE_W'(tgt_idx)]  = '0;
                count_nxt[QUEUE_W'(tgt_idx)] = '0;
                outcome_nxt = OC_EXITED;
              end else if (!nr_found_r) begin
                outcome_nxt = OC_NO_READY;
              end else begin
                op_nxt    = OP_PUSH;
                q_nxt     = QUEUE_W'(tgt_idx);
                val_nxt   = cur_r;
                i_nxt     = '0;
                state_nxt = S_QRD;
              end
            end else begin
              mark_nxt  = ST_WAITING;
              state_nxt = S_SWITCH;
            end
          end
          ACT_EXIT: begin
            if (step_r == 2'd0) begin
              if (count_r[cur_q] == '0) begin
                if (!nr_found_r) begin
                  outcome_nxt = OC_NO_READY;
                end else begin
                  mark_nxt  = ST_EXITED;
                  state_nxt = S_SWITCH;
                end
              end else begin
                // walk the joiners, noting which ones a wake would move
                op_nxt    = OP_SCANQ;
                q_nxt     = cur_q;
                i_nxt     = '0;
                state_nxt = S_QRD;
              end
            end else begin
              if (!nr_found_r && mask_r == '0) begin
                outcome_nxt = OC_NO_READY;
              end else begin
                for (int j = 0; j < THREAD_SLOTS; j++) begin
                  if (mask_r[j]) begin
                    status_nxt[j] = ST_READY;
                  end
                end
                head_nxt[cur_q]  = '0;
                count_nxt[cur_q] = '0;
                mark_nxt     = ST_ABSENT;
                k_nxt        = '0;
                nr_found_nxt = 1'b0;
                rescan_nxt   = 1'b1;
                state_nxt    = S_SCAN;
              end
            end
          end
          ACT_LOCK: begin
            if (step_r == 2'd0) begin
              if (!li_ok) begin
                outcome_nxt = OC_OK;
              end else if (!held_li) begin
                held_nxt[li_idx]  = 1'b1;
                owner_nxt[li_idx] = cur_r;
              end else if (owner_r[li_idx] == cur_r) begin
                outcome_nxt = OC_OK;
              end else if (!nr_found_r) begin
                outcome_nxt = OC_NO_READY;
              end else begin
                op_nxt    = OP_PUSH;
                q_nxt     = lock_q;
                val_nxt   = cur_r;
                i_nxt     = '0;
                state_nxt = S_QRD;
              end
            end else begin
              mark_nxt  = ST_WAITING;
              state_nxt = S_SWITCH;
            end
          end
          ACT_UNLOCK: begin
            if (step_r == 2'd0) begin
              if (li_ok && held_li) begin
                if (count_r[lock_q] == '0) begin
                  held_nxt[li_idx]  = 1'b0;
                  owner_nxt[li_idx] = '0;
                end else begin
                  op_nxt    = OP_POP;
                  q_nxt     = lock_q;
                  state_nxt = S_QRD;
                end
              end
            end else begin
              // hand the lock straight to the first waiter
              owner_nxt[li_idx] = w_r;
              if (32'(w_r) < THREAD_SLOTS && status_r[w_r] == ST_WAITING) begin
                status_nxt[w_r] = ST_READY;
              end
            end
          end
          ACT_WAIT: begin
            case (step_r)
              2'd0: begin
                if (li_ok && ci_ok) begin
                  state_nxt = S_DISP;
                  if (held_li && count_r[lock_q] != '0) begin
                    op_nxt    = OP_PEEK;
                    q_nxt     = lock_q;
                    state_nxt = S_QRD;
                  end else begin
                    step_nxt = 2'd1;
                  end
                end
              end
              2'd1: begin
                if (!nr_found_r && !peek_ok_r) begin
                  outcome_nxt = OC_NO_READY;
                end else begin
                  op_nxt    = OP_PUSH;
                  q_nxt     = cv_q;
                  val_nxt   = cur_r;
                  i_nxt     = '0;
                  state_nxt = S_QRD;
                end
              end
              2'd2: begin
                mark_nxt     = ST_WAITING;
                k_nxt        = '0;
                nr_found_nxt = 1'b0;
                rescan_nxt   = 1'b1;
                state_nxt    = S_SCAN;
                if (held_li) begin
                  if (count_r[lock_q] == '0) begin
                    held_nxt[li_idx]  = 1'b0;
                    owner_nxt[li_idx] = '0;
                  end else begin
                    op_nxt    = OP_POP;
                    q_nxt     = lock_q;
                    state_nxt = S_QRD;
                  end
                end
              end
              default: begin
                owner_nxt[li_idx] = w_r;
                if (32'(w_r) < THREAD_SLOTS && status_r[w_r] == ST_WAITING) begin
                  status_nxt[w_r] = ST_READY;
                end
                mark_nxt     = ST_WAITING;
                k_nxt        = '0;
                nr_found_nxt = 1'b0;
                rescan_nxt   = 1'b1;
                state_nxt    = S_SCAN;
              end
            endcase
          end
          ACT_SIGNAL: begin
            case (step_r)
              2'd0: begin
                if (li_ok && ci_ok && count_r[cv_q] != '0) begin
                  op_nxt    = OP_POP;
                  q_nxt     = cv_q;
                  state_nxt = S_QRD;
                end
              end
              2'd1: begin
                if (!held_li) begin
                  held_nxt[li_idx]  = 1'b1;
                  owner_nxt[li_idx] = w_r;
                  if (32'(w_r) < THREAD_SLOTS && status_r[w_r] == ST_WAITING) begin
                    status_nxt[w_r] = ST_READY;
                  end
                end else begin
                  op_nxt    = OP_PUSH;
                  q_nxt     = lock_q;
                  val_nxt   = w_r;
                  i_nxt     = '0;
                  state_nxt = S_QRD;
                end
              end
              default: begin
                outcome_nxt = OC_OK;
              end
            endcase
          end
          default: begin
            outcome_nxt = OC_OK;
          end
        endcase
      end

      // queue walker: issue a ram read, or end the walk; a push then writes its entry if the queue has room
      S_QRD: begin
        state_nxt = S_QDAT;
        case (op_r)
          OP_PUSH: begin
            if (i_r >= qcnt) begin
              step_nxt  = step_r + 2'd1;
              state_nxt = S_DISP;
              if (qcnt < CNT_W'(THREAD_SLOTS)) begin
                ram_we          = 1'b1;
                ram_addr        = {q_r, slot_add(qhd, SLOT_W'(qcnt))};
                count_nxt[q_r]  = qcnt + CNT_W'(1);
              end
            end
          end
          OP_SCANQ: begin
            if (i_r >= qcnt) begin
              step_nxt  = step_r + 2'd1;
              state_nxt = S_DISP;
            end
          end
          default: begin
            ram_addr = {q_r, qhd};
          end
        endcase
      end

      S_QDAT: begin
        state_nxt = S_QRD;
        case (op_r)
          OP_PUSH: begin
            if (ram_rdata == val_r) begin
              // already queued, nothing to add
              step_nxt  = step_r + 2'd1;
              state_nxt = S_DISP;
            end else begin
              i_nxt = i_r + CNT_W'(1);
            end
          end
          OP_SCANQ: begin
            if (32'(ram_rdata) < THREAD_SLOTS && ram_rdata != cur_r &&
                status_r[ram_rdata] == ST_WAITING) begin
              mask_nxt[ram_rdata] = 1'b1;
            end
            i_nxt = i_r + CNT_W'(1);
          end
          OP_POP: begin
            w_nxt          = ram_rdata;
            head_nxt[q_r]  = slot_add(qhd, SLOT_W'(1));
            count_nxt[q_r] = qcnt - CNT_W'(1);
            step_nxt       = step_r + 2'd1;
            state_nxt      = S_DISP;
          end
          default: begin
            peek_ok_nxt = 32'(ram_rdata) < THREAD_SLOTS && ram_rdata != cur_r &&
                          status_r[ram_rdata] == ST_WAITING;
            step_nxt    = step_r + 2'd1;
            state_nxt   = S_DISP;
          end
        endcase
      end

      // current slot takes its mark, the ready slot found runs
      S_SWITCH: begin
        status_nxt[cur_r] = mark_r;
        if (nr_found_r) begin
          status_nxt[nr_idx_r] = ST_RUNNING;
          cur_nxt              = nr_idx_r;
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt   = 1'b1;
          out_run_nxt     = SLOTOUT_W'(cur_r);
          out_created_nxt = SLOTOUT_W'(created_r);
          out_sw_nxt      = (cur_r != before_r);
          out_oc_nxt      = outcome_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      cur_r       <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < THREAD_SLOTS; j++) begin
        status_r[j] <= (j == 0) ? ST_RUNNING : ST_ABSENT;
      end
      for (int j = 0; j < NUM_QUEUES; j++) begin
        head_r[j]  <= '0;
        count_r[j] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      cur_r       <= cur_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r         <= act_nxt;
    tgt_r         <= tgt_nxt;
    li_r          <= li_nxt;
    ci_r          <= ci_nxt;
    owner_r       <= owner_nxt;
    k_r           <= k_nxt;
    abs_found_r   <= abs_found_nxt;
    abs_idx_r     <= abs_idx_nxt;
    nr_found_r    <= nr_found_nxt;
    nr_idx_r      <= nr_idx_nxt;
    rescan_r      <= rescan_nxt;
    mark_r        <= mark_nxt;
    op_r          <= op_nxt;
    q_r           <= q_nxt;
    val_r         <= val_nxt;
    i_r           <= i_nxt;
    w_r           <= w_nxt;
    peek_ok_r     <= peek_ok_nxt;
    mask_r        <= mask_nxt;
    created_r     <= created_nxt;
    outcome_r     <= outcome_nxt;
    before_r      <= before_nxt;
    out_run_r     <= out_run_nxt;
    out_created_r <= out_created_nxt;
    out_sw_r      <= out_sw_nxt;
    out_oc_r      <= out_oc_nxt;
  end

  // the current slot is always the running one between requests
  a_cur_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (status_r[cur_r] == ST_RUNNING))
    else $error("current slot not running while idle");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> (state_r == S_SCAN))
    else $error("accepted request did not start the slot scan");

  a_ram_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_QDAT) |-> ($past(state_r) == S_QRD))
    else $error("queue data used without a read issued");

endmodule

/* tb/tb_sched_pkg.sv */
`timescale 1ns / 1ps
package tb_sched_pkg;
  import tsu_pkg::*;

  typedef struct packed {
    logic [3:0] running;
    logic [3:0] created;
    logic       switched;
    logic [2:0] outcome;
  } sched_rsp_t;

  // golden scheduler state and per-request prediction
  class sched_scoreboard;
    status_t    status [THREAD_SLOTS];
    int         cur;
    int         qent [NUM_QUEUES][THREAD_SLOTS];
    int         qhead [NUM_QUEUES];
    int         qcnt [NUM_QUEUES];
    bit         held [LOCK_COUNT];
    int         owner [LOCK_COUNT];
    sched_rsp_t pending [$];
    int         mismatches;
    int         checked;

    function new();
      for (int i = 0; i < THREAD_SLOTS; i++) status[i] = ST_ABSENT;
      status[0] = ST_RUNNING;
      cur = 0;
      for (int q = 0; q < NUM_QUEUES; q++) begin
        qhead[q] = 0;
        qcnt[q] = 0;
      end
      for (int l = 0; l < LOCK_COUNT; l++) begin
        held[l] = 0;
        owner[l] = 0;
      end
      mismatches = 0;
      checked = 0;
    endfunction

    function bit q_has(int q, int v);
      for (int i = 0; i < qcnt[q]; i++)
        if (qent[q][(qhead[q] + i) % THREAD_SLOTS] == v) return 1;
      return 0;
    endfunction

    function void q_push(int q, int v);
      if (q_has(q, v) || qcnt[q] >= THREAD_SLOTS) return;
      qent[q][(qhead[q] + qcnt[q]) % THREAD_SLOTS] = v;
      qcnt[q]++;
    endfunction

    function int q_pop(int q);
      int v;
      v = qent[q][qhead[q]];
      qhead[q] = (qhead[q] + 1) % THREAD_SLOTS;
      qcnt[q]--;
      return v;
    endfunction

    function void wake(int s);
      if (status[s] == ST_WAITING) status[s] = ST_READY;
    endfunction

    function int next_ready();
      int s;
      for (int k = 1; k < THREAD_SLOTS; k++) begin
        s = (cur + k) % THREAD_SLOTS;
        if (status[s] == ST_READY) return s;
      end
      return THREAD_SLOTS;
    endfunction

    function void release_lock(int l);
      int w;
      if (!held[l]) return;
      if (qcnt[THREAD_SLOTS + l] > 0) begin
        w = q_pop(THREAD_SLOTS + l);
        owner[l] = w;
        wake(w);
      end else begin
        held[l] = 0;
        owner[l] = 0;
      end
    endfunction

    function void switch_away(status_t mark);
      int n;
      n = next_ready();
      status[cur] = mark;
      if (n < THREAD_SLOTS) begin
        status[n] = ST_RUNNING;
        cur = n;
      end
    endfunction

    // apply one accepted request and queue the predicted response
    function void note_request(action_t act, int tgt, int li, int ci);
      int         prev, s, w, lq, cq;
      bit         any, joiners;
      sched_rsp_t r;
      prev = cur;
      r = '0;
      r.outcome = OC_OK;
      lq = THREAD_SLOTS + li;
      cq = THREAD_SLOTS + LOCK_COUNT + ci;
      case (act)
        ACT_CREATE: begin
          s = THREAD_SLOTS;
          for (int i = THREAD_SLOTS - 1; i >= 0; i--)
            if (status[i] == ST_ABSENT) s = i;
          if (s == THREAD_SLOTS) r.outcome = OC_NO_SLOT;
          else begin
            qhead[s] = 0;
            qcnt[s] = 0;
            status[cur] = ST_READY;
            status[s] = ST_RUNNING;
            cur = s;
            r.created = 4'(s);
          end
        end
        ACT_YIELD: begin
          if (next_ready() == THREAD_SLOTS) r.outcome = OC_NO_READY;
          else switch_away(ST_READY);
        end
        ACT_JOIN: begin
          if (tgt == cur || status[tgt] == ST_ABSENT) r.outcome = OC_ABSENT;
          else if (status[tgt] == ST_EXITED) begin
            status[tgt] = ST_ABSENT;
            qhead[tgt] = 0;
            qcnt[tgt] = 0;
            r.outcome = OC_EXITED;
          end else if (next_ready() == THREAD_SLOTS) r.outcome = OC_NO_READY;
          else begin
            q_push(tgt, cur);
            switch_away(ST_WAITING);
          end
        end
        ACT_EXIT: begin
          any = next_ready() < THREAD_SLOTS;
          joiners = qcnt[cur] > 0;
          for (int i = 0; i < qcnt[cur]; i++) begin
            w = qent[cur][(qhead[cur] + i) % THREAD_SLOTS];
            if (w != cur && status[w] == ST_WAITING) any = 1;
          end
          if (!any) r.outcome = OC_NO_READY;
          else begin
            while (qcnt[cur] > 0) wake(q_pop(cur));
            qhead[cur] = 0;
            switch_away(joiners ? ST_ABSENT : ST_EXITED);
          end
        end
        ACT_LOCK: begin
          if (!held[li]) begin
            held[li] = 1;
            owner[li] = cur;
          end else if (owner[li] != cur) begin
            if (next_ready() == THREAD_SLOTS) r.outcome = OC_NO_READY;
            else begin
              q_push(lq, cur);
              switch_away(ST_WAITING);
            end
          end
        end
        ACT_UNLOCK: release_lock(li);
        ACT_WAIT: begin
          any = next_ready() < THREAD_SLOTS;
          if (held[li] && qcnt[lq] > 0) begin
            w = qent[lq][qhead[lq]];
            if (w != cur && status[w] == ST_WAITING) any = 1;
          end
          if (!any) r.outcome = OC_NO_READY;
          else begin
            q_push(cq, cur);
            release_lock(li);
            switch_away(ST_WAITING);
          end
        end
        default: begin
          if (qcnt[cq] > 0) begin
            w = q_pop(cq);
            if (!held[li]) begin
              held[li] = 1;
              owner[li] = w;
              wake(w);
            end else q_push(lq, w);
          end
        end
      endcase
      r.running = 4'(cur);
      r.switched = (cur != prev);
      pending.push_back(r);
    endfunction

    function void check_response(sched_rsp_t got);
      sched_rsp_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected run=%0d new=%0d sw=%0d oc=%0d, got run=%0d new=%0d sw=%0d oc=%0d",
                   want.running, want.created, want.switched, want.outcome,
                   got.running, got.created, got.switched, got.outcome);
      end
    endfunction
  endclass
endpackage

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
  import tsu_pkg::*;
  import tb_sched_pkg::*;

  logic clk;
  logic rst_n;

  tsu_in_if  req_ch ();
  tsu_out_if rsp_ch ();

  thread_scheduler_sync_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch.sink),
    .out_rsp (rsp_ch.source)
  );

  sched_scoreboard sb;

  // idle percentages for sender and receiver, changed per phase
  int  send_idle;
  int  recv_idle;
  // receiver hold-off in cycles, counted by the receiver process
  int  hold_cycles;
  int  sent;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // hard time limit covering the worst-case requests plus long stalls
  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // offer one request, hold it until the handshake
  task automatic send_request(action_t act, logic [3:0] tgt, logic [2:0] li,
                              logic [2:0] ci);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.action        <= act;
    req_ch.target_thread <= tgt;
    req_ch.lock_index    <= li;
    req_ch.condvar_index <= ci;
    do @(posedge clk); while (!req_ch.ready);
    // accepted at this edge: predict now
    sb.note_request(act, tgt, li, ci);
    sent++;
  endtask

  // random request, mostly well-formed thread traffic on a few locks
  task automatic send_random();
    action_t    act;
    logic [3:0] tgt;
    logic [2:0] li, ci;
    int         pick;
    pick = $urandom_range(99);
    // create weighted so the slot table fills and drains
    if (pick < 16) act = ACT_CREATE;
    else if (pick < 30) act = ACT_YIELD;
    else if (pick < 42) act = ACT_JOIN;
    else if (pick < 54) act = ACT_EXIT;
    else if (pick < 70) act = ACT_LOCK;
    else if (pick < 82) act = ACT_UNLOCK;
    else if (pick < 91) act = ACT_WAIT;
    else act = ACT_SIGNAL;
    tgt = 4'($urandom);
    // narrow lock and condvar sets raise contention, sometimes full range
    li = ($urandom_range(3) == 0) ? 3'($urandom) : 3'($urandom_range(1));
    ci = ($urandom_range(3) == 0) ? 3'($urandom) : 3'($urandom_range(1));
    send_request(act, tgt, li, ci);
  endtask

  // wait for every predicted response to arrive
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // receiver: random stalls plus an optional long hold-off
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_ch.valid && rsp_ch.ready)
        sb.check_response({rsp_ch.running_thread, rsp_ch.created_thread,
                           rsp_ch.switched, rsp_ch.outcome});
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp_ch.ready <= 1'b0;
      end else
        rsp_ch.ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
    end
  end

  initial begin
    sb = new();
    send_idle = 0;
    recv_idle = 0;
    hold_cycles = 0;
    sent = 0;
    req_ch.valid         <= 1'b0;
    req_ch.action        <= ACT_CREATE;
    req_ch.target_thread <= '0;
    req_ch.lock_index    <= '0;
    req_ch.condvar_index <= '0;
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (THREAD_SLOTS + 4) @(posedge clk);

    // directed: nothing ready at reset, self join, absent join
    send_request(ACT_YIELD, 4'd0, 3'd0, 3'd0);
    send_request(ACT_EXIT, 4'd0, 3'd0, 3'd0);
    send_request(ACT_JOIN, 4'd0, 3'd0, 3'd0);
    send_request(ACT_JOIN, 4'd15, 3'd7, 3'd7);
    send_request(ACT_WAIT, 4'd0, 3'd7, 3'd7);
    // lock, relock by owner, then a create switches away
    send_request(ACT_LOCK, 4'd0, 3'd0, 3'd0);
    send_request(ACT_LOCK, 4'd0, 3'd0, 3'd0);
    send_request(ACT_CREATE, 4'd0, 3'd0, 3'd0);
    // contended lock blocks slot 1, slot 0 runs and hands it over
    send_request(ACT_LOCK, 4'd0, 3'd0, 3'd0);
    send_request(ACT_UNLOCK, 4'd0, 3'd0, 3'd0);
    send_request(ACT_UNLOCK, 4'd0, 3'd7, 3'd0);
    // cond wait on a free lock, then signal wakes with the lock
    send_request(ACT_WAIT, 4'd0, 3'd3, 3'd5);
    send_request(ACT_SIGNAL, 4'd0, 3'd3, 3'd5);
    send_request(ACT_SIGNAL, 4'd0, 3'd3, 3'd5);
    // exit without joiners, then join of an exited slot
    send_request(ACT_CREATE, 4'd0, 3'd0, 3'd0);
    send_request(ACT_EXIT, 4'd0, 3'd0, 3'd0);
    send_request(ACT_JOIN, 4'd2, 3'd0, 3'd0);
    // fill every slot, then one more create finds none free
    repeat (15) send_request(ACT_CREATE, 4'd0, 3'd0, 3'd0);
    send_request(ACT_JOIN, 4'd3, 3'd0, 3'd0);
    send_request(ACT_EXIT, 4'd0, 3'd0, 3'd0);
    drain();

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1) ? 88 : (ph == 3) ? 13 : 0;
      recv_idle = (ph == 2) ? 88 : (ph == 3) ? 13 : 0;
      if (ph == 0) begin
        // long receiver hold-off while requests keep coming
        hold_cycles = 400;
      end
      repeat (180) send_random();
      // sender pauses until all responses are in
      drain();
    end

    drain();
    $display("ran %0d requests over four idle phases with a long output stall", sent);
    $display("responses checked %0d, mismatches %0d", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule

/* filelist.f */
rtl/tsu_pkg.sv
rtl/tsu_in_if.sv
rtl/tsu_out_if.sv
rtl/tsu_ram.sv
rtl/thread_scheduler_sync_unit.sv
tb/tb_sched_pkg.sv
tb/tb.sv
